/* hdl/qats_pkg.sv */
// Shared types, codes and constants of the quote-aware token splitter.
package qats_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int SEP_MAX_DEF    = 4;
  localparam int FIFO_DEPTH_DEF = 4;

  // Character codes.
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPLIT_MODE = 2'd0;
  localparam logic [1:0] REG_SEP_LEN    = 2'd1;
  localparam logic [1:0] REG_SEP_BYTES  = 2'd2;

  // Split modes.
  localparam logic MODE_SEP = 1'b0;
  localparam logic MODE_WS  = 1'b1;

  // Register reset values.
  localparam logic        RST_SPLIT_MODE = MODE_WS;
  localparam logic [2:0]  RST_SEP_LEN    = 3'd1;
  localparam logic [31:0] RST_SEP_BYTES  = 32'd124;

  // One result word.
  typedef struct packed {
    logic [7:0] char_out;
    logic       token_last;
    logic       is_separator;
    logic       string_last;
    logic       no_char;
  } qats_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qats_fifo_stat_t;

  // Space, tab, newline, vertical tab, form feed or return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* hdl/qats_if.sv */
// Handshake interfaces for the input, result and configuration channels.
interface qats_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_end;

  modport source (output valid, output char_in, output string_end, input ready);
  modport sink (input valid, input char_in, input string_end, output ready);
endinterface

interface qats_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       token_last;
  logic       is_separator;
  logic       string_last;
  logic       no_char;

  modport source (output valid, output char_out, output token_last, output is_separator,
                  output string_last, output no_char, input ready);
  modport sink (input valid, input char_out, input token_last, input is_separator,
                input string_last, input no_char, output ready);
endinterface

interface qats_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* hdl/qats_front.sv */
// Front end: configuration registers, quote tracking, separator matching and word bundling.
module qats_front #(
  parameter int SEP_MAX = qats_pkg::SEP_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  qats_in_if.sink                               in_ch,
  qats_cfg_if.sink                              cfg_ch,
  input  qats_pkg::qats_fifo_stat_t             fifo_stat,
  output logic                                  push,
  output qats_pkg::qats_item_t [SEP_MAX:0]      push_items,
  output logic [$clog2(SEP_MAX+1)-1:0]          push_last
);

  localparam int WD  = (SEP_MAX > 1) ? SEP_MAX - 1 : 1;
  localparam int WCW = (SEP_MAX > 1) ? $clog2(SEP_MAX) : 1;
  localparam int CW  = $clog2(SEP_MAX + 2);
  localparam int IW  = $clog2(SEP_MAX + 1);

  logic        mode_r;
  logic [2:0]  sep_len_r;
  logic [31:0] sep_bytes_r;
  logic        sgl_r, sgl_nxt;
  logic        dbl_r, dbl_nxt;
  logic [7:0]  win_r [WD];
  logic [7:0]  win_nxt [WD];
  logic [WCW-1:0] win_cnt_r, win_cnt_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;

  logic        acc;
  logic [7:0]  c;
  logic        e;

  logic [7:0]  sb [SEP_MAX];
  logic [7:0]  pb [SEP_MAX];
  logic [7:0]  qv [SEP_MAX+1];
  logic [SEP_MAX-1:0] cand;
  logic [CW-1:0] wn, n, len, s_sel, k, hv, stream_len, cnt_c, cnt_raw, o_base, qi;
  logic        pre, is_q, in_q, ws, sep_hit, sep_case, endtok, keep_win, ok;
  qats_pkg::qats_item_t it;

  assign c   = in_ch.char_in;
  assign e   = in_ch.string_end;
  assign in_ch.ready  = !fifo_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    // Separator bytes; those beyond the fourth read as zero.
    for (int t = 0; t < SEP_MAX; t++) begin
      sb[t] = (t < 4) ? sep_bytes_r[(t % 4) * 8 +: 8] : 8'h00;
    end

    wn = CW'(win_cnt_r);
    n  = wn + CW'(1);

    // Pending bytes: the match window followed by the new byte.
    for (int i = 0; i < SEP_MAX; i++) begin
      pb[i] = 8'h00;
      if (CW'(i) == wn) begin
        pb[i] = c;
      end else if ((i < SEP_MAX - 1) && (CW'(i) < wn)) begin
        pb[i] = win_r[i % WD];
      end
    end
    qv[0] = held_r;
    for (int i = 0; i < SEP_MAX; i++) begin
      qv[i+1] = pb[i];
    end

    if (sep_len_r == 3'd0) begin
      len = CW'(1);
    end else if (int'(sep_len_r) > SEP_MAX) begin
      len = CW'(SEP_MAX);
    end else begin
      len = CW'(sep_len_r);
    end

    ws  = (mode_r == qats_pkg::MODE_WS);
    pre = ws || (n > len);

    // Start position of each possible new window. Position zero trusts the
    // bytes already in the window; later positions are checked byte by byte.
    cand = '0;
    for (int t = 0; t < SEP_MAX; t++) begin
      if (CW'(t) == wn) begin
        cand[0] = !pre && (c == sb[t]);
      end
    end
    for (int s = 1; s < SEP_MAX; s++) begin
      ok = (CW'(s) < n) && (!pre || (CW'(s) >= wn));
      for (int i = s; i < SEP_MAX; i++) begin
        if ((CW'(i) < n) && (pb[i] != sb[i-s])) begin
          ok = 1'b0;
        end
      end
      cand[s] = ok;
    end
    s_sel = n;
    for (int s = SEP_MAX - 1; s >= 0; s--) begin
      if (cand[s]) begin
        s_sel = CW'(s);
      end
    end
    sep_hit = (s_sel < n) && ((n - s_sel) == len);

    // Classify the byte.
    is_q     = (c == qats_pkg::CH_SQUOTE) || (c == qats_pkg::CH_DQUOTE);
    in_q     = sgl_r || dbl_r;
    k        = n;
    endtok   = e;
    sep_case = 1'b0;
    keep_win = 1'b0;
    if (is_q || in_q) begin
      k = n;
    end else if (ws) begin
      if (qats_pkg::is_space(c)) begin
        k      = n - CW'(1);
        endtok = 1'b1;
      end
    end else if (sep_hit) begin
      k        = s_sel;
      sep_case = 1'b1;
      endtok   = 1'b1;
    end else if (!e) begin
      k        = s_sel;
      keep_win = 1'b1;
    end

    // Word count: token bytes (the newest one stays held unless the token
    // ends), then the separator bytes.
    hv         = CW'(held_v_r);
    stream_len = hv + k;
    if (endtok) begin
      cnt_c = stream_len;
    end else if (stream_len != '0) begin
      cnt_c = stream_len - CW'(1);
    end else begin
      cnt_c = '0;
    end
    cnt_raw = cnt_c + (sep_case ? (n - k) : CW'(0));
    o_base  = held_v_r ? CW'(0) : CW'(1);

    for (int j = 0; j <= SEP_MAX; j++) begin
      it = '0;
      qi = o_base + CW'(j);
      for (int i = 0; i <= SEP_MAX; i++) begin
        if (CW'(i) == qi) begin
          it.char_out = qv[i];
        end
      end
      it.token_last   = (endtok && (qi == k)) || (sep_case && (qi == n));
      it.is_separator = sep_case && (qi > k);
      it.string_last  = e && ((CW'(j) + CW'(1)) == cnt_raw);
      push_items[j]   = it;
    end
    if (e && (cnt_raw == '0)) begin
      push_items[0]             = '0;
      push_items[0].string_last = 1'b1;
      push_items[0].no_char     = 1'b1;
      push                      = acc;
      push_last                 = '0;
    end else begin
      push      = acc && (cnt_raw != '0);
      push_last = IW'(cnt_raw - CW'(1));
    end

    // Next state.
    held_v_nxt = !e && !endtok && (stream_len != '0);
    held_nxt   = held_r;
    for (int i = 0; i <= SEP_MAX; i++) begin
      if (CW'(i) == k) begin
        held_nxt = qv[i];
      end
    end
    win_cnt_nxt = keep_win ? WCW'(n - s_sel) : '0;
    for (int i = 0; i < WD; i++) begin
      win_nxt[i] = win_r[i];
      for (int t = 0; t < SEP_MAX; t++) begin
        if (CW'(t) == (s_sel + CW'(i))) begin
          win_nxt[i] = pb[t];
        end
      end
    end
    sgl_nxt = sgl_r ^ ((c == qats_pkg::CH_SQUOTE) && !dbl_r);
    dbl_nxt = dbl_r ^ ((c == qats_pkg::CH_DQUOTE) && !sgl_r);
    if (e) begin
      sgl_nxt = 1'b0;
      dbl_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= qats_pkg::RST_SPLIT_MODE;
      sep_len_r   <= qats_pkg::RST_SEP_LEN;
      sep_bytes_r <= qats_pkg::RST_SEP_BYTES;
      sgl_r       <= 1'b0;
      dbl_r       <= 1'b0;
      win_cnt_r   <= '0;
      held_v_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          qats_pkg::REG_SPLIT_MODE: mode_r      <= cfg_ch.wr_data[0];
          qats_pkg::REG_SEP_LEN:    sep_len_r   <= cfg_ch.wr_data[2:0];
          qats_pkg::REG_SEP_BYTES:  sep_bytes_r <= cfg_ch.wr_data;
          default: ;
        endcase
      end
      if (acc) begin
        sgl_r     <= sgl_nxt;
        dbl_r     <= dbl_nxt;
        win_cnt_r <= win_cnt_nxt;
        held_v_r  <= held_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
      for (int i = 0; i < WD; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

/* hdl/qats_fifo.sv */
// Bundle queue between the front end and the output serializer.
module qats_fifo #(
  parameter int SEP_MAX    = qats_pkg::SEP_MAX_DEF,
  parameter int FIFO_DEPTH = qats_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  qats_pkg::qats_item_t [SEP_MAX:0]  push_items,
  input  logic [$clog2(SEP_MAX+1)-1:0]      push_last,
  input  logic                              pop,
  output qats_pkg::qats_fifo_stat_t         fifo_stat,
  output qats_pkg::qats_item_t [SEP_MAX:0]  head_items,
  output logic [$clog2(SEP_MAX+1)-1:0]      head_last
);

  // Depth must be at least two.
  localparam int PW   = $clog2(FIFO_DEPTH);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);
  localparam int IW   = $clog2(SEP_MAX + 1);

  qats_pkg::qats_item_t [SEP_MAX:0] ent_items [FIFO_DEPTH];
  logic [IW-1:0]   ent_last [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign fifo_stat.full  = (cnt_r == CNTW'(FIFO_DEPTH));
  assign fifo_stat.empty = (cnt_r == '0);
  assign head_items = ent_items[rd_ptr_r];
  assign head_last  = ent_last[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNTW'(1);
      2'b01:   cnt_nxt = cnt_r - CNTW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_items[wr_ptr_r] <= push_items;
      ent_last[wr_ptr_r]  <= push_last;
    end
  end

endmodule

/* hdl/qats_back.sv */
// Back end: steps through the head bundle and drives the registered result channel.
module qats_back #(
  parameter int SEP_MAX = qats_pkg::SEP_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qats_pkg::qats_fifo_stat_t         fifo_stat,
  input  qats_pkg::qats_item_t [SEP_MAX:0]  head_items,
  input  logic [$clog2(SEP_MAX+1)-1:0]      head_last,
  output logic                              pop,
  qats_out_if.source                        out_ch
);

  localparam int IW = $clog2(SEP_MAX + 1);

  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  qats_pkg::qats_item_t out_item_r;
  logic                 ld;

  assign ld  = !fifo_stat.empty && (!out_valid_r || out_ch.ready);
  assign pop = ld && (idx_r == head_last);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_out     = out_item_r.char_out;
  assign out_ch.token_last   = out_item_r.token_last;
  assign out_ch.is_separator = out_item_r.is_separator;
  assign out_ch.string_last  = out_item_r.string_last;
  assign out_ch.no_char      = out_item_r.no_char;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (ld) begin
      idx_nxt       = pop ? '0 : idx_r + IW'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_item_r <= head_items[idx_r];
    end
  end

endmodule

/* hdl/quote_aware_token_splitter.sv */
// Quote-aware token splitter: splits a byte stream into tokens, one result word per cycle while the receiver is ready.
// Data path: each accepted byte's bundle is registered in the bundle queue, and its words pass the output register.
// Throughput: one input byte per cycle while the bundle queue has room; the result side sends
//   one word per cycle while the receiver takes it, so the words of a byte leave one by one.
// Reset (synchronous, rst_n low): quote, window and held-byte state, the queue and the output
//   register are cleared; the registers return to whitespace mode, length 1, separator '|'.
module quote_aware_token_splitter #(
  parameter int SEP_MAX    = qats_pkg::SEP_MAX_DEF,
  parameter int FIFO_DEPTH = qats_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qats_in_if.sink     in_ch,
  qats_out_if.source  out_ch,
  qats_cfg_if.sink    cfg_ch
);

  // The front end turns every accepted byte into one bundle of up to SEP_MAX + 1
  // result words, all worked out in the cycle of acceptance. A bundle with no
  // word is not queued. The back end walks the head bundle one word per cycle
  // into the output register while the receiver takes them, so a new byte can
  // enter while older words still wait to be taken.

  qats_pkg::qats_fifo_stat_t          fifo_stat;
  qats_pkg::qats_item_t [SEP_MAX:0]   push_items;
  qats_pkg::qats_item_t [SEP_MAX:0]   head_items;
  logic [$clog2(SEP_MAX+1)-1:0]       push_last;
  logic [$clog2(SEP_MAX+1)-1:0]       head_last;
  logic                               push;
  logic                               pop;

  qats_front #(
    .SEP_MAX(SEP_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_items(push_items),
    .push_last (push_last)
  );

  qats_fifo #(
    .SEP_MAX   (SEP_MAX),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_items(push_items),
    .push_last (push_last),
    .pop       (pop),
    .fifo_stat (fifo_stat),
    .head_items(head_items),
    .head_last (head_last)
  );

  qats_back #(
    .SEP_MAX(SEP_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .head_items(head_items),
    .head_last (head_last),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // The front end never writes a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("bundle written into a full queue");

  // The back end never takes from an empty queue.
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("bundle taken from an empty queue");

  // The last byte of a string always yields at least one word.
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.string_end) |-> push)
    else $error("string end produced no result word");

  // A word without a byte only marks the end of a string.
  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_char) |->
      (out_ch.string_last && !out_ch.token_last && !out_ch.is_separator))
    else $error("string end marker carries token flags");

endmodule

/* verif/quote_aware_token_splitter_checker.sv */
`timescale 1ns / 100ps
// Checker of the token splitter: predicts result words from accepted input words and compares.
module quote_aware_token_splitter_checker
  import qats_pkg::*;
#(
  parameter int SEP_MAX = SEP_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qats_in_if          in_ch,
  qats_out_if         out_ch,
  qats_cfg_if         cfg_ch,
  output int unsigned fail_count,
  output int unsigned words_due
);

  // Shadow registers.
  logic        mode_reg;
  logic [2:0]  sep_len_reg;
  logic [31:0] sep_word_reg;

  // Shadow splitter state.
  logic        sq_open;
  logic        dq_open;
  logic [7:0]  window_q [SEP_MAX];
  int unsigned window_fill;
  logic [7:0]  held_byte;
  logic        held_ok;

  qats_item_t  step_words[$];
  qats_item_t  words_expected[$];

  task automatic report(input string msg);
    fail_count++;
    $display("%0t ERROR %s", $realtime, msg);
  endtask

  function automatic int unsigned sep_span();
    int unsigned l;
    l = int'(sep_len_reg);
    if (l == 0) l = 1;
    if (l > SEP_MAX) l = SEP_MAX;
    return l;
  endfunction

  function automatic logic [7:0] sep_at(input int unsigned k);
    if (k >= 4) return 8'h00;
    return sep_word_reg[8*k +: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic void add_word(input logic [7:0] c, input logic tl, input logic sp);
    qats_item_t w;
    w.char_out     = c;
    w.token_last   = tl;
    w.is_separator = sp;
    w.string_last  = 1'b0;
    w.no_char      = 1'b0;
    if (step_words.size() < SEP_MAX + 1) step_words.push_back(w);
  endfunction

  // A token byte is held back until the next byte tells whether it ends its token.
  function automatic void token_byte(input logic [7:0] c);
    if (held_ok) add_word(held_byte, 1'b0, 1'b0);
    held_byte = c;
    held_ok   = 1'b1;
  endfunction

  function automatic void close_token();
    if (held_ok) add_word(held_byte, 1'b1, 1'b0);
    held_ok = 1'b0;
  endfunction

  function automatic void drain_window();
    int unsigned k;
    for (k = 0; k < window_fill && k < SEP_MAX; k++) token_byte(window_q[k]);
    window_fill = 0;
  endfunction

  // Left to right, non-overlapping separator search; on a mismatch the oldest
  // window byte leaves as a token byte and the rest is searched again.
  function automatic void match_sep(input logic [7:0] c);
    logic [7:0]  pend[$];
    logic [7:0]  rest[$];
    logic [7:0]  b;
    int unsigned w;
    int unsigned span;
    int unsigned k;
    span = sep_span();
    pend.push_back(c);
    while (pend.size() > 0) begin
      b = pend[0];
      w = window_fill;
      if (w < SEP_MAX && b == sep_at(w)) begin
        if (w + 1 >= span) begin
          close_token();
          for (k = 0; k < w; k++) add_word(window_q[k], 1'b0, 1'b1);
          add_word(b, 1'b1, 1'b1);
          window_fill = 0;
        end else begin
          window_q[w] = b;
          window_fill = w + 1;
        end
        void'(pend.pop_front());
      end else if (w == 0) begin
        token_byte(b);
        void'(pend.pop_front());
      end else begin
        rest.delete();
        for (k = 1; k < w; k++) rest.push_back(window_q[k]);
        for (k = 0; k < pend.size(); k++) rest.push_back(pend[k]);
        token_byte(window_q[0]);
        window_fill = 0;
        pend = rest;
      end
    end
  endfunction

  function automatic void split_byte(input logic [7:0] c, input logic last);
    logic       ws;
    qats_item_t tail;
    step_words.delete();
    ws = (mode_reg == MODE_WS);
    if (ws || window_fill + 1 > sep_span()) drain_window();
    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      if (c == CH_SQUOTE && !dq_open) sq_open = ~sq_open;
      else if (c == CH_DQUOTE && !sq_open) dq_open = ~dq_open;
      drain_window();
      token_byte(c);
    end else if (sq_open || dq_open) begin
      drain_window();
      token_byte(c);
    end else if (ws) begin
      if (is_blank(c)) close_token();
      else token_byte(c);
    end else begin
      match_sep(c);
    end
    if (last) begin
      drain_window();
      close_token();
      if (step_words.size() == 0) begin
        tail = '0;
        tail.no_char = 1'b1;
      end else begin
        tail = step_words.pop_back();
      end
      tail.string_last = 1'b1;
      step_words.push_back(tail);
      sq_open     = 1'b0;
      dq_open     = 1'b0;
      window_fill = 0;
      held_ok     = 1'b0;
    end
    foreach (step_words[i]) words_expected.push_back(step_words[i]);
  endfunction

  task automatic check_word();
    qats_item_t want;
    if (words_expected.size() == 0) begin
      report($sformatf("result word %02h with nothing expected", out_ch.char_out));
      return;
    end
    want = words_expected.pop_front();
    if (out_ch.char_out !== want.char_out)
      report($sformatf("char_out %02h, expected %02h", out_ch.char_out, want.char_out));
    if (out_ch.token_last !== want.token_last)
      report($sformatf("token_last %b, expected %b", out_ch.token_last, want.token_last));
    if (out_ch.is_separator !== want.is_separator)
      report($sformatf("is_separator %b, expected %b", out_ch.is_separator,
                       want.is_separator));
    if (out_ch.string_last !== want.string_last)
      report($sformatf("string_last %b, expected %b", out_ch.string_last, want.string_last));
    if (out_ch.no_char !== want.no_char)
      report($sformatf("no_char %b, expected %b", out_ch.no_char, want.no_char));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count   = 0;
      mode_reg     = RST_SPLIT_MODE;
      sep_len_reg  = RST_SEP_LEN;
      sep_word_reg = RST_SEP_BYTES;
      sq_open      = 1'b0;
      dq_open      = 1'b0;
      window_fill  = 0;
      held_ok      = 1'b0;
      words_expected.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_SPLIT_MODE: mode_reg     = cfg_ch.wr_data[0];
          REG_SEP_LEN:    sep_len_reg  = cfg_ch.wr_data[2:0];
          REG_SEP_BYTES:  sep_word_reg = cfg_ch.wr_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) split_byte(in_ch.char_in, in_ch.string_end);
      if (out_ch.valid && out_ch.ready) check_word();
    end
    words_due <= words_expected.size();
  end

endmodule

/* verif/quote_aware_token_splitter_tb.sv */
`timescale 1ns / 100ps
// Top of the token splitter testbench: clock, reset, stimulus and the final verdict.
module quote_aware_token_splitter_tb;
  import qats_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The slowest
  // correct stretch is a drain of a few result words under a 77 percent receiver stall.
  localparam int STALL_LIMIT   = 4000;
  // Extra cycles after the last expected word, covering the lag of the checker's
  // registered count of expected words.
  localparam int SETTLE_CYCLES = 8;
  localparam int SEGMENTS      = 12;
  localparam int SEG_WORDS     = 29;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned words_due;
  int unsigned stall_cycles = 0;

  // Idle rates in percent of cycles for the sender and the receiver.
  int unsigned send_idle;
  int unsigned recv_idle;

  // Copy of the programmed registers, used to steer the random bytes.
  logic        cur_mode;
  logic [2:0]  cur_len;
  logic [31:0] cur_sep;

  qats_in_if  in_ch ();
  qats_out_if out_ch ();
  qats_cfg_if cfg_ch ();

  quote_aware_token_splitter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  quote_aware_token_splitter_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always #1 clk = ~clk;

  // The receiver decides once per cycle, at the falling edge, whether it takes a word.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog expired", $realtime);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Separator length as the block uses it: 0 counts as 1, above 4 counts as 4.
  function automatic int unsigned sep_span();
    if (cur_len == 0) return 1;
    if (cur_len > SEP_MAX_DEF) return SEP_MAX_DEF;
    return int'(cur_len);
  endfunction

  function automatic logic [7:0] sep_char(input int unsigned k);
    return cur_sep[8*k +: 8];
  endfunction

  // Separator bytes come mostly from a small alphabet, so that the random text
  // produces partial matches, overlaps and broken prefixes often.
  function automatic logic [7:0] rand_sep_char();
    case ($urandom_range(4))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h7C;
      3:       return 8'h2C;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A text byte: separator bytes, whitespace, quotes, the letters a to d, and now and
  // then any byte at all.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return sep_char($urandom_range(sep_span() - 1));
    if (r < 40) begin
      if ($urandom_range(5) == 0) return CH_SPACE;
      return CH_TAB + 8'($urandom_range(4));
    end
    if (r < 50) return ($urandom_range(1) == 0) ? CH_SQUOTE : CH_DQUOTE;
    if (r < 70) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  // Offer one input word, after a random number of idle cycles, and hold it until taken.
  // When no idle cycle is drawn, the valid line stays high from one word straight into the next.
  task automatic push_byte(input logic [7:0] c, input logic last);
    logic idle;
    idle = ($urandom_range(99) < send_idle);
    @(negedge clk);
    while (idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      idle = ($urandom_range(99) < send_idle);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_in    <= c;
    in_ch.string_end <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every predicted result word has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers change only when the block is idle. The count of expected words is
  // registered and lags the block, so wait a little longer as well. Strings are usually
  // left open across the change on purpose.
  task automatic set_config(input logic mode, input logic [2:0] len, input logic [31:0] sep);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SPLIT_MODE, {31'd0, mode});
    write_reg(REG_SEP_LEN, {29'd0, len});
    write_reg(REG_SEP_BYTES, sep);
    cur_mode = mode;
    cur_len  = len;
    cur_sep  = sep;
  endtask

  // One chunk of text: either a whole separator in a row or a single byte.
  task automatic send_chunk(inout int unsigned count);
    int unsigned n;
    int unsigned k;
    if (cur_mode == MODE_SEP && $urandom_range(99) < 20) begin
      n = sep_span();
      for (k = 0; k < n; k++) begin
        push_byte(sep_char(k), (k == n - 1) && ($urandom_range(9) == 0));
        count++;
      end
    end else begin
      push_byte(pick_byte(), $urandom_range(9) == 0);
      count++;
    end
  endtask

  task automatic random_segment(input int unsigned seg);
    int unsigned sent;
    logic [31:0] sep;
    sent = 0;
    // The first segments pin the register extremes; the rest are drawn at random.
    case (seg)
      0: set_config(MODE_SEP, 3'd4, 32'hFFFF_FFFF);
      1: set_config(MODE_WS, 3'd7, 32'h0000_0000);
      2: set_config(MODE_SEP, 3'd1, 32'h0000_0000);
      3: set_config(MODE_SEP, 3'd0, 32'h0000_007C);
      default: begin
        sep = {rand_sep_char(), rand_sep_char(), rand_sep_char(), rand_sep_char()};
        set_config(($urandom_range(9) < 7) ? MODE_SEP : MODE_WS, 3'($urandom_range(7)), sep);
      end
    endcase
    while (sent < SEG_WORDS) begin
      send_chunk(sent);
      // Now and then the sender stops until all results are back.
      if ($urandom_range(49) == 0) hold_until_drained();
    end
  endtask

  initial begin
    int unsigned seg;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_in    = 8'h00;
    in_ch.string_end = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_SPLIT_MODE;
    cfg_ch.wr_data   = 32'd0;
    cur_mode         = RST_SPLIT_MODE;
    cur_len          = RST_SEP_LEN;
    cur_sep          = RST_SEP_BYTES;
    send_idle        = 24;
    recv_idle        = 77;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Whitespace mode out of reset: byte extremes, a double quote inside single quotes,
    // blanks inside quotes, a run of blanks, and a string made only of a blank, which
    // yields a lone end-of-string word with no byte.
    push_byte(8'h00, 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_SQUOTE, 1'b0);
    push_byte(CH_DQUOTE, 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_SQUOTE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_CR, 1'b1);
    push_byte(CH_SPACE, 1'b1);

    // Three-byte separator "abc": a broken prefix, a full match, and a prefix that is
    // still pending when the string ends.
    set_config(MODE_SEP, 3'd3, 32'h0063_6261);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b1);

    // Length zero acts as one; the string stays open into the next setting.
    set_config(MODE_SEP, 3'd0, 32'h0000_002C);
    push_byte(8'h2C, 1'b0);
    push_byte(8'h6B, 1'b0);
    push_byte(8'h2C, 1'b0);

    // Length seven acts as four, and the separator holds a quote, so it never matches:
    // the quote breaks the prefix and then protects the last comma.
    set_config(MODE_SEP, 3'd7, 32'h2C27_2C2C);
    push_byte(8'h2C, 1'b0);
    push_byte(8'h2C, 1'b0);
    push_byte(CH_SQUOTE, 1'b0);
    push_byte(8'h2C, 1'b1);

    // Random text in three idling profiles: slow receiver, slow sender, then full rate.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        send_idle = 77;
        recv_idle = 24;
      end else if (seg == 2 * SEGMENTS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_segment(seg);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
